// ===== rtl/thermal_scalar_damage_eval_defines.svh =====
// Assertion macros shared by the damage evaluator RTL.
`ifndef THERMAL_SCALAR_DAMAGE_EVAL_DEFINES_SVH
`define THERMAL_SCALAR_DAMAGE_EVAL_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TSDE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define TSDE_NEVER(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(prop)) else $error(msg);
`else
`define TSDE_ASSERT(label, prop, msg)
`define TSDE_NEVER(label, prop, msg)
`endif
`endif

// ===== rtl/tsde_pkg.sv =====
// Types and constants shared by the damage evaluator modules.
`timescale 1ns / 1ps
`default_nettype none
package tsde_pkg;
	localparam int TSDE_EXP_TERMS = 8;
	localparam int TEMP_LAT = 8;
	localparam int STRAIN_W = 32;
	localparam int RATIO_Q = 31;
	localparam int GAMMA_Q = 57;
	localparam int PM_W = 24;
	localparam int DIV_GAP = GAMMA_Q - RATIO_Q;

	localparam logic signed [16:0] TEMP_BASE = 17'sd320;
	localparam logic signed [16:0] TEMP_HIGH = 17'sd12960;
	localparam logic [18:0] K_A = 19'd268435;
	localparam logic [22:0] K_B = 23'd6543114;
	localparam logic [20:0] K_C = 21'd1174405;
	localparam logic [15:0] LN2_Q16 = 16'd45426;
	localparam logic [31:0] ONE_Q30 = 32'd1073741824;
	localparam logic [22:0] X_SAT = 23'd4194304;
	localparam logic [27:0] RCP25 = 28'((64'd1 << 32) / 64'd25);
	localparam logic [24:0] RCP_LN2 = 25'((64'd1 << 40) / 64'd45426);

	typedef enum logic {
		REG_THRESHOLD = 1'b0,
		REG_SOFTENING = 1'b1
	} tsde_reg_t;

	typedef struct packed {
		logic [31:0] peak_strain;
		logic signed [15:0] temperature;
		logic signed [15:0] peak_temperature;
		logic [15:0] thermal_damage;
	} tsde_in_t;

	typedef struct packed {
		logic [15:0] damage;
		logic elastic;
		logic temp_out_of_range;
	} tsde_out_t;

	typedef struct packed {
		logic elastic;
		logic nonpos;
		logic flag;
	} tsde_side_t;
endpackage
`default_nettype wire

// ===== rtl/thermal_scalar_damage_eval.sv =====
// Top level of the temperature-dependent scalar damage evaluator.
// The sample channel takes one integration point per word: peak strain,
// current and peak temperature and thermal damage. The result channel
// returns one word per sample, in order: damage, elastic flag and the
// temperature range flag. Both channels use valid and ready.
// The block accepts one sample every cycle while sample_ready is high.
// Its stages are the 8 temperature stages, two operand stages, the
// 57-stage softening-rate divider and the exponential, which takes six
// stages plus three for each of the EXP_TERMS-1 Taylor steps.
// Configuration must be written over APB only while no sample is in flight;
// the block does not enforce this. Register 0 at byte 0 is threshold_ratio,
// register 1 at byte 4 is softening_ratio. Both read back and reset to zero.
// Reset clears all valid bits and the registers; no result is pending after.
// When the receiver stalls, the pipeline keeps moving until a finished
// word reaches its last stage behind the held output word; only then is
// sample_ready lowered, and nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
`include "thermal_scalar_damage_eval_defines.svh"
module thermal_scalar_damage_eval
	import tsde_pkg::*;
#(
	parameter int EXP_TERMS = TSDE_EXP_TERMS
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [2:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input wire logic sample_valid,
	output logic sample_ready,
	input wire tsde_in_t sample,
	output logic result_valid,
	input wire logic result_ready,
	output tsde_out_t result
);
	localparam int EXP_LAT = 6 + 3 * (EXP_TERMS - 1);
	localparam int TOTAL = TEMP_LAT + 2 + GAMMA_Q + EXP_LAT;

	logic [31:0] thr_q, soft_q;
	logic v_s [TOTAL];
	logic [31:0] kap_s [TEMP_LAT];
	logic [15:0] chi_s [TEMP_LAT];
	logic [31:0] kap_s9, k0_s9, d_s9, kap_s10, d_s10;
	logic [47:0] m_s9;
	logic [PM_W-1:0] pm_s9, pm_s10;
	logic neg_s9, neg_s10;
	tsde_side_t side_s9, side_s10;
	logic [GAMMA_Q-1:0] numg_s10;
	logic [61:0] numr_s10;
	logic [31:0] d_sd [GAMMA_Q];
	logic neg_sd [GAMMA_Q];
	tsde_side_t side_sd [GAMMA_Q];
	logic [RATIO_Q-1:0] ratio_sd [DIV_GAP];
	tsde_out_t result_q;
	logic result_valid_q;

	logic adv;
	logic signed [38:0] kappa0;
	logic signed [24:0] p;
	logic flag;
	logic [RATIO_Q-1:0] ratio;
	logic [GAMMA_Q-1:0] gamma;
	logic [15:0] damage;
	tsde_side_t side_out;
	logic [48:0] m_full;

	assign pready = 1'b1;
	assign adv = !v_s[TOTAL-1] || !result_valid_q || result_ready;
	assign sample_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
			soft_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (tsde_reg_t'(paddr[2]))
				REG_THRESHOLD: thr_q <= pwdata;
				REG_SOFTENING: soft_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (tsde_reg_t'(paddr[2]))
			REG_THRESHOLD: prdata = thr_q;
			REG_SOFTENING: prdata = soft_q;
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TOTAL; i++)
				v_s[i] <= 1'b0;
		end else if (adv) begin
			v_s[0] <= sample_valid;
			for (int i = 1; i < TOTAL; i++)
				v_s[i] <= v_s[i-1];
		end
	end

	tsde_temp u_temp (
		.clk(clk),
		.en(adv),
		.temperature(sample.temperature),
		.peak_temperature(sample.peak_temperature),
		.thr(thr_q),
		.kappa0(kappa0),
		.p(p),
		.flag(flag)
	);

	assign m_full = (49'd65536 - 49'(chi_s[TEMP_LAT-1])) * 49'(soft_q);

	always_ff @(posedge clk) begin
		if (adv) begin
			kap_s[0] <= sample.peak_strain;
			chi_s[0] <= sample.thermal_damage;
			for (int i = 1; i < TEMP_LAT; i++) begin
				kap_s[i] <= kap_s[i-1];
				chi_s[i] <= chi_s[i-1];
			end
			kap_s9 <= kap_s[TEMP_LAT-1];
			k0_s9 <= kappa0[31:0];
			d_s9 <= kap_s[TEMP_LAT-1] - kappa0[31:0];
			m_s9 <= 48'(m_full);
			pm_s9 <= p[24] ? PM_W'(-p) : ((p == 25'sd0) ? PM_W'(1) : PM_W'(p));
			neg_s9 <= !p[24];
			side_s9.elastic <= $signed({7'b0, kap_s[TEMP_LAT-1]}) < kappa0;
			side_s9.nonpos <= kappa0 <= 39'sd0;
			side_s9.flag <= flag;
			numg_s10 <= GAMMA_Q'({m_s9, 8'b0}) + GAMMA_Q'(pm_s9 >> 1);
			numr_s10 <= {k0_s9, 30'b0};
			kap_s10 <= kap_s9;
			pm_s10 <= pm_s9;
			d_s10 <= d_s9;
			neg_s10 <= neg_s9;
			side_s10 <= side_s9;
			d_sd[0] <= d_s10;
			neg_sd[0] <= neg_s10;
			side_sd[0] <= side_s10;
			for (int i = 1; i < GAMMA_Q; i++) begin
				d_sd[i] <= d_sd[i-1];
				neg_sd[i] <= neg_sd[i-1];
				side_sd[i] <= side_sd[i-1];
			end
			ratio_sd[0] <= ratio;
			for (int i = 1; i < DIV_GAP; i++)
				ratio_sd[i] <= ratio_sd[i-1];
		end
	end

	tsde_div #(
		.QUO_W(RATIO_Q),
		.DEN_W(STRAIN_W)
	) u_div_ratio (
		.clk(clk),
		.en(adv),
		.num({1'b0, numr_s10}),
		.den(kap_s10),
		.quo(ratio)
	);

	tsde_div #(
		.QUO_W(GAMMA_Q),
		.DEN_W(PM_W)
	) u_div_gamma (
		.clk(clk),
		.en(adv),
		.num({PM_W'(0), numg_s10}),
		.den(pm_s10),
		.quo(gamma)
	);

	tsde_exp #(
		.EXP_TERMS(EXP_TERMS)
	) u_exp (
		.clk(clk),
		.en(adv),
		.gamma(gamma),
		.d(d_sd[GAMMA_Q-1]),
		.neg(neg_sd[GAMMA_Q-1]),
		.ratio(ratio_sd[DIV_GAP-1]),
		.side_in(side_sd[GAMMA_Q-1]),
		.damage(damage),
		.side_out(side_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv && v_s[TOTAL-1]) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s[TOTAL-1]) begin
			result_q.damage <= damage;
			result_q.elastic <= side_out.elastic;
			result_q.temp_out_of_range <= side_out.flag;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

	`TSDE_NEVER(a_elastic_zero, result_valid && result.elastic && result.damage != 16'd0, "elastic word carries damage")
	`TSDE_ASSERT(a_ready_stall, !sample_ready |-> result_valid && !result_ready, "sample side stalled without output stall")
	`TSDE_ASSERT(a_tail_moves, adv && v_s[TOTAL-1] |=> result_valid, "finished word not presented")
endmodule
`default_nettype wire

// ===== rtl/tsde_temp.sv =====
// Temperature stages: normalized temperature, threshold factor, energy factor, kappa0.
`timescale 1ns / 1ps
`default_nettype none
module tsde_temp
	import tsde_pkg::*;
(
	input wire logic clk,
	input wire logic en,
	input wire logic signed [15:0] temperature,
	input wire logic signed [15:0] peak_temperature,
	input wire logic [31:0] thr,
	output logic signed [38:0] kappa0,
	output logic signed [24:0] p,
	output logic flag
);
	logic [26:0] a_s1, a_s2;
	logic neg_s1, neg_s2, neg_s3, neg_s4, kneg_s7;
	logic flag_s1, flag_s2, flag_s3, flag_s4, flag_s5, flag_s6, flag_s7, flag_s8;
	logic [54:0] prod_s2;
	logic [20:0] thmag_s3;
	logic [41:0] th2_s4;
	logic [43:0] bprod_s4;
	logic [60:0] aprod_s5;
	logic [62:0] cprod_s5;
	logic signed [20:0] bterm_s5;
	logic signed [22:0] f1_s6;
	logic signed [24:0] p_s6, p_s7, p_s8;
	logic [52:0] kprod_s7;
	logic signed [38:0] kappa0_s8;

	logic signed [15:0] traw;
	logic signed [16:0] tn;
	logic [16:0] tmag;
	logic [22:0] q_est;
	logic [26:0] rem;
	logic [19:0] rb;
	logic [20:0] at;
	logic [22:0] ct;
	logic [20:0] f1mag;
	logic [37:0] km;

	always_comb begin
		traw = (temperature > peak_temperature) ? temperature : peak_temperature;
		tn = 17'(traw) - TEMP_BASE;
		tmag = tn[16] ? 17'(-tn) : 17'(tn);
		q_est = prod_s2[54:32];
		rem = a_s2 - 27'(q_est) * 27'd25;
		rb = 20'((bprod_s4 + 44'd8388608) >> 24);
		at = 21'((aprod_s5 + 61'd549755813888) >> 40);
		ct = 23'((cprod_s5 + 63'd549755813888) >> 40);
		f1mag = f1_s6[22] ? 21'(-f1_s6) : 21'(f1_s6);
		km = 38'((kprod_s7 + 53'd32768) >> 16);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= {tmag[15:0], 10'b0} + 27'd12;
			neg_s1 <= tn[16];
			flag_s1 <= (17'(traw) < TEMP_BASE) || (17'(traw) > TEMP_HIGH);
			prod_s2 <= 55'(a_s1) * 55'(RCP25);
			a_s2 <= a_s1;
			neg_s2 <= neg_s1;
			flag_s2 <= flag_s1;
			thmag_s3 <= (rem >= 27'd25) ? 21'(q_est + 23'd1) : 21'(q_est);
			neg_s3 <= neg_s2;
			flag_s3 <= flag_s2;
			th2_s4 <= 42'(thmag_s3) * 42'(thmag_s3);
			bprod_s4 <= 44'(thmag_s3) * 44'(K_B);
			neg_s4 <= neg_s3;
			flag_s4 <= flag_s3;
			aprod_s5 <= 61'(th2_s4) * 61'(K_A);
			cprod_s5 <= 63'(th2_s4) * 63'(K_C);
			bterm_s5 <= neg_s4 ? -$signed({1'b0, rb}) : $signed({1'b0, rb});
			flag_s5 <= flag_s4;
			f1_s6 <= 23'sd65536 - $signed({2'b0, at});
			p_s6 <= 25'sd65536 + 25'(bterm_s5) - $signed({2'b0, ct});
			flag_s6 <= flag_s5;
			kprod_s7 <= 53'(thr) * 53'(f1mag);
			kneg_s7 <= f1_s6[22];
			p_s7 <= p_s6;
			flag_s7 <= flag_s6;
			kappa0_s8 <= kneg_s7 ? -$signed({1'b0, km}) : $signed({1'b0, km});
			p_s8 <= p_s7;
			flag_s8 <= flag_s7;
		end
	end

	assign kappa0 = kappa0_s8;
	assign p = p_s8;
	assign flag = flag_s8;
endmodule
`default_nettype wire

// ===== rtl/tsde_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module tsde_div
	import tsde_pkg::*;
#(
	parameter int QUO_W = RATIO_Q,
	parameter int DEN_W = STRAIN_W
) (
	input wire logic clk,
	input wire logic en,
	input wire logic [QUO_W+DEN_W-1:0] num,
	input wire logic [DEN_W-1:0] den,
	output logic [QUO_W-1:0] quo
);
	logic [DEN_W-1:0] rem_s [QUO_W];
	logic [QUO_W-1:0] low_s [QUO_W];
	logic [QUO_W-1:0] quo_s [QUO_W];
	logic [DEN_W-1:0] den_s [QUO_W];

	for (genvar i = 0; i < QUO_W; i++) begin : g_stage
		logic [DEN_W-1:0] rin;
		logic [QUO_W-1:0] lin;
		logic [QUO_W-1:0] qin;
		logic [DEN_W-1:0] din;
		logic [DEN_W:0] trial;
		logic ge;
		if (i == 0) begin : g_first
			assign rin = num[QUO_W+DEN_W-1:QUO_W];
			assign lin = num[QUO_W-1:0];
			assign qin = '0;
			assign din = den;
		end else begin : g_next
			assign rin = rem_s[i-1];
			assign lin = low_s[i-1];
			assign qin = quo_s[i-1];
			assign din = den_s[i-1];
		end
		assign trial = {rin, lin[QUO_W-1]};
		assign ge = trial >= {1'b0, din};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? DEN_W'(trial - {1'b0, din}) : DEN_W'(trial);
				low_s[i] <= {lin[QUO_W-2:0], 1'b0};
				quo_s[i] <= {qin[QUO_W-2:0], ge};
				den_s[i] <= din;
			end
		end
	end

	assign quo = quo_s[QUO_W-1];
endmodule
`default_nettype wire

// ===== rtl/tsde_exp.sv =====
// Exponent argument, range reduction, Taylor series stages and final damage.
`timescale 1ns / 1ps
`default_nettype none
module tsde_exp
	import tsde_pkg::*;
#(
	parameter int EXP_TERMS = TSDE_EXP_TERMS
) (
	input wire logic clk,
	input wire logic en,
	input wire logic [GAMMA_Q-1:0] gamma,
	input wire logic [31:0] d,
	input wire logic neg,
	input wire logic [RATIO_Q-1:0] ratio,
	input wire tsde_side_t side_in,
	output logic [15:0] damage,
	output tsde_side_t side_out
);
	typedef struct packed {
		logic [15:0] r;
		logic [7:0] n;
		logic [RATIO_Q-1:0] ratio;
		tsde_side_t side;
	} carry_t;

	logic [59:0] pphi_s1;
	logic [60:0] pplo_s1;
	logic neg_s1, neg_s2, neg_s3;
	logic [RATIO_Q-1:0] ratio_s1, ratio_s2, ratio_s3;
	tsde_side_t side_s1, side_s2, side_s3, side_s5, side_s6;
	logic [22:0] xm_s2, xm_s3;
	logic [47:0] qp_s3;
	carry_t car_s4;
	logic [62:0] prod_s5;
	logic [7:0] n_s5;
	logic [15:0] dmg_s6;

	logic [89:0] gd;
	logic [7:0] q_est, q;
	logic [22:0] rem0, rem;
	logic [31:0] accb [EXP_TERMS];
	carry_t carb [EXP_TERMS];
	logic signed [8:0] shf;
	logic [5:0] sa;
	logic [64:0] vbig;
	logic [15:0] dmg;

	always_comb begin
		gd = 90'({pphi_s1, 29'b0}) + 90'(pplo_s1);
		q_est = qp_s3[47:40];
		rem0 = xm_s3 - 23'(q_est) * 23'(LN2_Q16);
		q = (rem0 >= 23'(LN2_Q16)) ? q_est + 8'd1 : q_est;
		rem = (rem0 >= 23'(LN2_Q16)) ? rem0 - 23'(LN2_Q16) : rem0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pphi_s1 <= 60'(gamma[GAMMA_Q-1:29]) * 60'(d);
			pplo_s1 <= 61'(gamma[28:0]) * 61'(d);
			neg_s1 <= neg;
			ratio_s1 <= ratio;
			side_s1 <= side_in;
			xm_s2 <= (gd > (90'd1 << 58)) ? X_SAT : 23'((gd + (90'd1 << 35)) >> 36);
			neg_s2 <= neg_s1;
			ratio_s2 <= ratio_s1;
			side_s2 <= side_s1;
			qp_s3 <= 48'(xm_s2) * 48'(RCP_LN2);
			xm_s3 <= xm_s2;
			neg_s3 <= neg_s2;
			ratio_s3 <= ratio_s2;
			side_s3 <= side_s2;
			if (neg_s3) begin
				car_s4.n <= (rem != '0) ? 8'(-(q + 8'd1)) : 8'(-q);
				car_s4.r <= (rem != '0) ? 16'(23'(LN2_Q16) - rem) : 16'd0;
			end else begin
				car_s4.n <= q;
				car_s4.r <= 16'(rem);
			end
			car_s4.ratio <= ratio_s3;
			car_s4.side <= side_s3;
		end
	end

	assign accb[0] = ONE_Q30;
	assign carb[0] = car_s4;

	for (genvar j = 0; j < EXP_TERMS - 1; j++) begin : g_term
		localparam int K = EXP_TERMS - 1 - j;
		localparam logic [4:0] KC = 5'(K);
		localparam logic [32:0] RCP = 33'((64'd1 << 32) / K);
		logic [61:0] prod_s1;
		carry_t car_s1, car_s2, car_s3;
		logic [31:0] t_s2;
		logic [64:0] tp_s2;
		logic [31:0] acc_s3;
		logic [32:0] qe;
		logic [33:0] rk;
		logic [32:0] qk;
		always_comb begin
			qe = tp_s2[64:32];
			rk = 34'(t_s2) - 34'(qe * KC);
			qk = (rk >= 34'(KC)) ? qe + 33'd1 : qe;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				prod_s1 <= 62'(accb[j]) * 62'({carb[j].r, 14'b0});
				car_s1 <= carb[j];
				t_s2 <= prod_s1[61:30];
				tp_s2 <= 65'(prod_s1[61:30]) * 65'(RCP);
				car_s2 <= car_s1;
				acc_s3 <= 32'(33'(ONE_Q30) + qk);
				car_s3 <= car_s2;
			end
		end
		assign accb[j+1] = acc_s3;
		assign carb[j+1] = car_s3;
	end

	always_comb begin
		shf = 9'sd44 - 9'($signed(n_s5));
		sa = '0;
		vbig = '0;
		if (shf >= 9'sd63) begin
			vbig = '0;
		end else if (shf > 9'sd0) begin
			sa = 6'(shf);
			vbig = (65'(prod_s5) + (65'd1 << (sa - 6'd1))) >> sa;
		end else if (shf == 9'sd0) begin
			vbig = 65'(prod_s5);
		end else begin
			sa = 6'(-shf);
			if (64'(prod_s5) > (64'd65535 >> sa))
				vbig = 65'd65536;
			else
				vbig = 65'(prod_s5) << sa;
		end
		if (side_s5.elastic)
			dmg = 16'd0;
		else if (side_s5.nonpos)
			dmg = 16'hFFFF;
		else if (vbig >= 65'd65536)
			dmg = 16'd0;
		else if (vbig == '0)
			dmg = 16'hFFFF;
		else
			dmg = 16'(17'd65536 - 17'(vbig));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s5 <= 63'(carb[EXP_TERMS-1].ratio) * 63'(accb[EXP_TERMS-1]);
			n_s5 <= carb[EXP_TERMS-1].n;
			side_s5 <= carb[EXP_TERMS-1].side;
			dmg_s6 <= dmg;
			side_s6 <= side_s5;
		end
	end

	assign damage = dmg_s6;
	assign side_out = side_s6;
endmodule
`default_nettype wire
